// ===== design/badec_pkg.sv =====
package badec_pkg;

    // Result region codes
    typedef enum logic [3:0] {
        TGT_RAM     = 4'd0,
        TGT_BASIC   = 4'd1,
        TGT_KERNEL  = 4'd2,
        TGT_CHARROM = 4'd3,
        TGT_VIDEO   = 4'd4,
        TGT_SOUND   = 4'd5,
        TGT_COLOUR  = 4'd6,
        TGT_TIMER1  = 4'd7,
        TGT_TIMER2  = 4'd8,
        TGT_ROMLOW  = 4'd9,
        TGT_ROMHIGH = 4'd10,
        TGT_CARTREG = 4'd11,
        TGT_CARTRAM = 4'd12,
        TGT_PORT    = 4'd13
    } target_t;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        CFG_CART_ACTIVE  = 3'd0,
        CFG_EXROM_LINE   = 3'd1,
        CFG_GAME_LINE    = 3'd2,
        CFG_LOW_ROM      = 3'd3,
        CFG_HIGH_ROM     = 3'd4,
        CFG_FLASH_CART   = 3'd5
    } cfg_idx_t;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int PADDR_W    = 5;

    localparam logic [DATA_W-1:0] PORT_RESET = 8'h37;
    localparam logic [ADDR_W-1:0] PORT_ADDR  = 16'h0001;

    localparam logic [ADDR_W-1:0] ROMLOW_BASE  = 16'h8000;
    localparam logic [ADDR_W-1:0] ROMLOW_TOP   = 16'h9fff;
    localparam logic [ADDR_W-1:0] BASIC_BASE   = 16'ha000;
    localparam logic [ADDR_W-1:0] BASIC_TOP    = 16'hbfff;
    localparam logic [ADDR_W-1:0] ULTIMAX_TOP  = 16'hcfff;
    localparam logic [ADDR_W-1:0] KERNEL_BASE  = 16'he000;

endpackage

// ===== design/banked_address_decoder.sv =====
// An s_ transfer reaches m_ through two registers: the input register, then the result register.
// Throughput: one access per cycle; s_tready drops only when both registers hold an
// item and m_tready is low.
// The processor port register is updated as the write to address 1 leaves the input
// register, so the next access already sees the new banking.
// Reset (aresetn low, synchronous): both stages empty, port register 0x37, config bits 0.
module banked_address_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [0:0]  s_tuser,   // [0] action (1 = write)
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] offset, [23:16] read_data
    output logic [4:0]  m_tuser,   // [3:0] target, [4] ram_copy
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [badec_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // config bits
    logic cart_active_reg, exrom_line_reg, game_line_reg;
    logic low_rom_reg, high_rom_reg, flash_cart_reg;
    logic [badec_pkg::DATA_W-1:0] port_reg;
    logic [badec_pkg::DATA_W-1:0] port_next;

    // input stage
    logic                          in_valid_reg;
    logic                          in_wr_reg;
    logic [badec_pkg::ADDR_W-1:0]  in_addr_reg;
    logic [badec_pkg::DATA_W-1:0]  in_data_reg;

    // result stage
    logic                          out_valid_reg;
    badec_pkg::target_t            out_target_reg;
    logic [badec_pkg::ADDR_W-1:0]  out_offset_reg;
    logic [badec_pkg::DATA_W-1:0]  out_rdata_reg;
    logic                          out_copy_reg;

    logic advance;
    logic cfg_wr;
    badec_pkg::cfg_idx_t cfg_idx;

    // decode
    badec_pkg::target_t            tgt;
    logic [badec_pkg::ADDR_W-1:0]  off;
    logic [badec_pkg::DATA_W-1:0]  rd;
    logic                          copy;
    logic                          done;
    logic                          port_wr;
    logic                          io_range;
    logic                          io_hit;
    badec_pkg::target_t            io_tgt;
    logic [badec_pkg::ADDR_W-1:0]  io_off;
    logic                          io_copy;
    logic                          vis_basic, vis_kernel, vis_char, vis_io;
    logic [2:0]                    mode;
    logic [badec_pkg::ADDR_W-1:0]  a;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rdata_reg, out_offset_reg};
    assign m_tuser  = {out_copy_reg, out_target_reg};

    assign pready  = 1'b1;
    assign cfg_idx = badec_pkg::cfg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            badec_pkg::CFG_CART_ACTIVE: prdata = {31'd0, cart_active_reg};
            badec_pkg::CFG_EXROM_LINE:  prdata = {31'd0, exrom_line_reg};
            badec_pkg::CFG_GAME_LINE:   prdata = {31'd0, game_line_reg};
            badec_pkg::CFG_LOW_ROM:     prdata = {31'd0, low_rom_reg};
            badec_pkg::CFG_HIGH_ROM:    prdata = {31'd0, high_rom_reg};
            badec_pkg::CFG_FLASH_CART:  prdata = {31'd0, flash_cart_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // banking mode from the low three port bits
    assign a    = in_addr_reg;
    assign mode = port_reg[2:0];
    always_comb begin
        vis_basic  = mode inside {3'd3, 3'd7};
        vis_kernel = mode inside {3'd2, 3'd3, 3'd6, 3'd7};
        vis_char   = mode inside {3'd1, 3'd2, 3'd3};
        vis_io     = mode inside {3'd5, 3'd6, 3'd7};
    end

    assign io_range = (a[15:12] == 4'hd);

    // I/O page split; io_hit low means the access falls through to RAM
    always_comb begin
        io_hit  = 1'b1;
        io_tgt  = badec_pkg::TGT_RAM;
        io_off  = a;
        io_copy = 1'b0;
        case (a[11:10])
            2'b00: begin
                io_tgt = badec_pkg::TGT_VIDEO;
                io_off = {10'd0, a[5:0]};
            end
            2'b01: begin
                io_tgt = badec_pkg::TGT_SOUND;
                io_off = {11'd0, a[4:0]};
            end
            2'b10: begin
                io_tgt = badec_pkg::TGT_COLOUR;
                io_off = {6'd0, a[9:0]};
            end
            default: begin
                case (a[9:8])
                    2'b00: begin
                        io_tgt = badec_pkg::TGT_TIMER1;
                        io_off = {12'd0, a[3:0]};
                    end
                    2'b01: begin
                        io_tgt = badec_pkg::TGT_TIMER2;
                        io_off = {12'd0, a[3:0]};
                    end
                    2'b10: begin
                        // cartridge register only on writes with a cartridge in
                        io_hit  = in_wr_reg && cart_active_reg;
                        io_tgt  = badec_pkg::TGT_CARTREG;
                        io_off  = {8'd0, a[7:0]};
                        io_copy = 1'b1;
                    end
                    default: begin
                        io_hit = flash_cart_reg;
                        io_tgt = badec_pkg::TGT_CARTRAM;
                        io_off = {8'd0, a[7:0]};
                    end
                endcase
            end
        endcase
    end

    always_comb begin
        tgt     = badec_pkg::TGT_RAM;
        off     = a;
        rd      = '0;
        copy    = 1'b0;
        done    = 1'b0;
        port_wr = 1'b0;
        if (in_wr_reg) begin
            if (vis_io && io_range) begin
                if (io_hit) begin
                    tgt  = io_tgt;
                    off  = io_off;
                    copy = io_copy;
                end
            end else if (a == badec_pkg::PORT_ADDR) begin
                port_wr = 1'b1;
                tgt     = badec_pkg::TGT_PORT;
                off     = '0;
                rd      = in_data_reg;
            end
        end else begin
            if (cart_active_reg && a[15]) begin
                if (exrom_line_reg && !game_line_reg) begin
                    // ultimax
                    if (low_rom_reg && a <= badec_pkg::ROMLOW_TOP) begin
                        tgt  = badec_pkg::TGT_ROMLOW;
                        off  = {3'd0, a[12:0]};
                        done = 1'b1;
                    end else if (high_rom_reg && a >= badec_pkg::KERNEL_BASE) begin
                        tgt  = badec_pkg::TGT_ROMHIGH;
                        off  = {3'd0, a[12:0]};
                        done = 1'b1;
                    end else if (a >= badec_pkg::BASIC_BASE && a <= badec_pkg::ULTIMAX_TOP) begin
                        done = 1'b1;
                    end
                end else begin
                    if (low_rom_reg && !exrom_line_reg && port_reg[0] && port_reg[1]
                        && a <= badec_pkg::ROMLOW_TOP) begin
                        tgt  = badec_pkg::TGT_ROMLOW;
                        off  = {3'd0, a[12:0]};
                        done = 1'b1;
                    end else if (high_rom_reg && !game_line_reg && port_reg[1]
                        && a >= badec_pkg::BASIC_BASE && a <= badec_pkg::BASIC_TOP) begin
                        tgt  = badec_pkg::TGT_ROMHIGH;
                        off  = {3'd0, a[12:0]};
                        done = 1'b1;
                    end
                end
            end
            if (!done) begin
                if (vis_basic && a >= badec_pkg::BASIC_BASE && a <= badec_pkg::BASIC_TOP) begin
                    tgt = badec_pkg::TGT_BASIC;
                    off = {3'd0, a[12:0]};
                end else if (vis_kernel && a >= badec_pkg::KERNEL_BASE) begin
                    tgt = badec_pkg::TGT_KERNEL;
                    off = {3'd0, a[12:0]};
                end else if (vis_io && io_range) begin
                    if (io_hit) begin
                        tgt  = io_tgt;
                        off  = io_off;
                        copy = io_copy;
                    end
                end else if (vis_char && io_range) begin
                    tgt = badec_pkg::TGT_CHARROM;
                    off = {4'd0, a[11:0]};
                end else if (a == badec_pkg::PORT_ADDR) begin
                    tgt = badec_pkg::TGT_PORT;
                    off = '0;
                    rd  = port_reg;
                end
            end
        end
    end

    assign port_next = (advance && port_wr) ? in_data_reg : port_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cart_active_reg <= 1'b0;
            exrom_line_reg  <= 1'b0;
            game_line_reg   <= 1'b0;
            low_rom_reg     <= 1'b0;
            high_rom_reg    <= 1'b0;
            flash_cart_reg  <= 1'b0;
            port_reg        <= badec_pkg::PORT_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            port_reg <= port_next;
            if (cfg_wr) begin
                case (cfg_idx)
                    badec_pkg::CFG_CART_ACTIVE: cart_active_reg <= pwdata[0];
                    badec_pkg::CFG_EXROM_LINE:  exrom_line_reg  <= pwdata[0];
                    badec_pkg::CFG_GAME_LINE:   game_line_reg   <= pwdata[0];
                    badec_pkg::CFG_LOW_ROM:     low_rom_reg     <= pwdata[0];
                    badec_pkg::CFG_HIGH_ROM:    high_rom_reg    <= pwdata[0];
                    badec_pkg::CFG_FLASH_CART:  flash_cart_reg  <= pwdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_wr_reg   <= s_tuser[0];
            in_addr_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
        if (advance) begin
            out_target_reg <= tgt;
            out_offset_reg <= off;
            out_rdata_reg  <= rd;
            out_copy_reg   <= copy;
        end
    end

    a_port_update: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_wr_reg && in_addr_reg == badec_pkg::PORT_ADDR
        |=> port_reg == $past(in_data_reg))
        else $error("port register not updated by write transfer");

    a_copy_cartreg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[4] |-> m_tuser[3:0] == badec_pkg::TGT_CARTREG)
        else $error("ram_copy set outside cartridge register");

    a_rdata_port: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:0] != badec_pkg::TGT_PORT |-> m_tdata[23:16] == 8'd0)
        else $error("read data nonzero outside port");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    a_port_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(advance && port_wr) && $past(aresetn) |-> $stable(port_reg))
        else $error("port register changed without a port write");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import badec_pkg::*;

    localparam logic ACC_RD = 1'b0;
    localparam logic ACC_WR = 1'b1;

    // config settings as {flash, high_rom, low_rom, game, exrom, cart}
    localparam logic [5:0] CFG_NONE    = 6'b000000;
    localparam logic [5:0] CFG_ALL     = 6'b111111;
    localparam logic [5:0] CFG_ULTIMAX = (6'd1 << CFG_CART_ACTIVE) | (6'd1 << CFG_EXROM_LINE)
                                       | (6'd1 << CFG_LOW_ROM) | (6'd1 << CFG_HIGH_ROM);
    localparam logic [5:0] CFG_NORMAL  = (6'd1 << CFG_CART_ACTIVE) | (6'd1 << CFG_LOW_ROM)
                                       | (6'd1 << CFG_HIGH_ROM);
    localparam logic [5:0] CFG_GAME_HI = (6'd1 << CFG_CART_ACTIVE) | (6'd1 << CFG_GAME_LINE)
                                       | (6'd1 << CFG_LOW_ROM) | (6'd1 << CFG_HIGH_ROM)
                                       | (6'd1 << CFG_FLASH_CART);
    localparam logic [5:0] CFG_ULT_BARE = (6'd1 << CFG_CART_ACTIVE) | (6'd1 << CFG_EXROM_LINE);

    localparam cfg_idx_t CFG_REGS [6] = '{CFG_CART_ACTIVE, CFG_EXROM_LINE, CFG_GAME_LINE,
                                          CFG_LOW_ROM, CFG_HIGH_ROM, CFG_FLASH_CART};

    localparam int N_PHASES  = 8;
    localparam int PHASE_LEN = 62;
    localparam logic [5:0] PHASE_CFG [N_PHASES] = '{CFG_NONE, CFG_ULTIMAX, CFG_NORMAL, CFG_ALL,
                                                    CFG_GAME_HI, CFG_ULT_BARE, CFG_NONE, CFG_NONE};

    typedef struct packed {
        target_t     tgt;
        logic [15:0] off;
        logic [7:0]  rd;
        logic        copy;
    } access_result_t;

    typedef struct packed {
        logic [5:0]     cfg;
        logic           wr;
        logic [15:0]    addr;
        logic [7:0]     wd;
        logic           typed;
        access_result_t want;
    } dir_row_t;

    localparam access_result_t NO_EXP = '{TGT_RAM, 16'h0000, 8'h00, 1'b0};

    localparam int N_DIR = 28;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{CFG_NONE, ACC_RD, 16'h0001, 8'h00, 1'b1, '{TGT_PORT,    16'h0000, 8'h37, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'h0000, 8'h00, 1'b1, '{TGT_RAM,     16'h0000, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'ha000, 8'h00, 1'b1, '{TGT_BASIC,   16'h0000, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'hffff, 8'h00, 1'b1, '{TGT_KERNEL,  16'h1fff, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'hd000, 8'h00, 1'b1, '{TGT_VIDEO,   16'h0000, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'hd7ff, 8'h00, 1'b1, '{TGT_SOUND,   16'h001f, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'hdbff, 8'h00, 1'b1, '{TGT_COLOUR,  16'h03ff, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'hdc0f, 8'h00, 1'b1, '{TGT_TIMER1,  16'h000f, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_WR, 16'hddff, 8'hff, 1'b1, '{TGT_TIMER2,  16'h000f, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'hde00, 8'h00, 1'b1, '{TGT_RAM,     16'hde00, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_WR, 16'hdeff, 8'hff, 1'b1, '{TGT_RAM,     16'hdeff, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'hdfff, 8'h00, 1'b1, '{TGT_RAM,     16'hdfff, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_WR, 16'ha000, 8'hff, 1'b1, '{TGT_RAM,     16'ha000, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_WR, 16'h0001, 8'hff, 1'b1, '{TGT_PORT,    16'h0000, 8'hff, 1'b0}},
        '{CFG_NONE, ACC_WR, 16'h0001, 8'h00, 1'b1, '{TGT_PORT,    16'h0000, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'he000, 8'h00, 1'b1, '{TGT_RAM,     16'he000, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_WR, 16'h0001, 8'h33, 1'b1, '{TGT_PORT,    16'h0000, 8'h33, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'hd000, 8'h00, 1'b1, '{TGT_CHARROM, 16'h0000, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_WR, 16'h0001, 8'h34, 1'b1, '{TGT_PORT,    16'h0000, 8'h34, 1'b0}},
        '{CFG_NONE, ACC_RD, 16'hd020, 8'h00, 1'b1, '{TGT_RAM,     16'hd020, 8'h00, 1'b0}},
        '{CFG_NONE, ACC_WR, 16'h0001, 8'h37, 1'b1, '{TGT_PORT,    16'h0000, 8'h37, 1'b0}},
        '{CFG_ALL,  ACC_RD, 16'hdf42, 8'h00, 1'b1, '{TGT_CARTRAM, 16'h0042, 8'h00, 1'b0}},
        '{CFG_ALL,  ACC_WR, 16'hde10, 8'h5a, 1'b1, '{TGT_CARTREG, 16'h0010, 8'h00, 1'b1}},
        '{CFG_ULTIMAX, ACC_RD, 16'h8000, 8'h00, 1'b1, '{TGT_ROMLOW,  16'h0000, 8'h00, 1'b0}},
        '{CFG_ULTIMAX, ACC_RD, 16'hffff, 8'h00, 1'b1, '{TGT_ROMHIGH, 16'h1fff, 8'h00, 1'b0}},
        '{CFG_ULTIMAX, ACC_RD, 16'hc000, 8'h00, 1'b1, '{TGT_RAM,     16'hc000, 8'h00, 1'b0}},
        '{CFG_NORMAL,  ACC_RD, 16'h9fff, 8'h00, 1'b1, '{TGT_ROMLOW,  16'h1fff, 8'h00, 1'b0}},
        '{CFG_NORMAL,  ACC_RD, 16'ha000, 8'h00, 1'b0, NO_EXP}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [15:0] address, [23:16] write_data
    logic [0:0]  s_tuser  = '0;   // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [15:0] offset, [23:16] read_data
    logic [4:0]  m_tuser;         // [3:0] target, [4] ram_copy
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    banked_address_decoder i_dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [5:0] cfg_now  = CFG_NONE;
    logic [7:0] port_reg = PORT_RESET;

    access_result_t expected_results [$];
    int n_errors   = 0;
    int n_accesses = 0;
    int n_results  = 0;
    int n_configs  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    task automatic flag_error(input string what, input int unsigned got, input int unsigned want);
        if (n_errors < 40)
            $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    // I/O page decode; leaves the RAM default when nothing in the page answers
    function automatic access_result_t decode_io(input logic [15:0] a, input logic wr,
                                                 input access_result_t dflt);
        access_result_t r;
        r = dflt;
        if (a <= 16'hd3ff) begin
            r.tgt = TGT_VIDEO;   r.off = a & 16'h003f;
        end else if (a <= 16'hd7ff) begin
            r.tgt = TGT_SOUND;   r.off = a & 16'h001f;
        end else if (a <= 16'hdbff) begin
            r.tgt = TGT_COLOUR;  r.off = a - 16'hd800;
        end else if (a <= 16'hdcff) begin
            r.tgt = TGT_TIMER1;  r.off = a & 16'h000f;
        end else if (a <= 16'hddff) begin
            r.tgt = TGT_TIMER2;  r.off = a & 16'h000f;
        end else if (a <= 16'hdeff) begin
            if (wr && cfg_now[CFG_CART_ACTIVE]) begin
                r.tgt = TGT_CARTREG; r.off = a & 16'h00ff; r.copy = 1'b1;
            end
        end else if (cfg_now[CFG_FLASH_CART]) begin
            r.tgt = TGT_CARTRAM; r.off = a & 16'h00ff;
        end
        return r;
    endfunction

    // Routes one access and tracks the processor port register
    function automatic access_result_t decode_access(input logic wr, input logic [15:0] a,
                                                     input logic [7:0] d);
        access_result_t r;
        logic [2:0] mode;
        logic basic_vis, kern_vis, chr_vis, io_vis, in_io, hit;
        logic cart, exrom, game, lo_rom, hi_rom;
        mode      = port_reg[2:0];
        basic_vis = (mode == 3'd3) || (mode == 3'd7);
        kern_vis  = (mode == 3'd2) || (mode == 3'd3) || (mode == 3'd6) || (mode == 3'd7);
        chr_vis   = (mode == 3'd1) || (mode == 3'd2) || (mode == 3'd3);
        io_vis    = (mode == 3'd5) || (mode == 3'd6) || (mode == 3'd7);
        in_io     = (a[15:12] == 4'hd);
        cart   = cfg_now[CFG_CART_ACTIVE];
        exrom  = cfg_now[CFG_EXROM_LINE];
        game   = cfg_now[CFG_GAME_LINE];
        lo_rom = cfg_now[CFG_LOW_ROM];
        hi_rom = cfg_now[CFG_HIGH_ROM];
        r   = '{TGT_RAM, a, 8'h00, 1'b0};
        hit = 1'b0;
        if (wr) begin
            if (io_vis && in_io) begin
                r = decode_io(a, 1'b1, r);
            end else if (a == PORT_ADDR) begin
                port_reg = d;
                r.tgt = TGT_PORT; r.off = '0; r.rd = d;
            end
        end else begin
            if (cart && a >= ROMLOW_BASE) begin
                if (exrom && !game) begin
                    // ultimax: ROM windows, open space below I/O
                    if (lo_rom && a <= ROMLOW_TOP) begin
                        r.tgt = TGT_ROMLOW; r.off = a - ROMLOW_BASE; hit = 1'b1;
                    end else if (hi_rom && a >= KERNEL_BASE) begin
                        r.tgt = TGT_ROMHIGH; r.off = a - KERNEL_BASE; hit = 1'b1;
                    end else if (a >= BASIC_BASE && a <= ULTIMAX_TOP) begin
                        hit = 1'b1;
                    end
                end else begin
                    if (lo_rom && !exrom && port_reg[0] && port_reg[1] && a <= ROMLOW_TOP) begin
                        r.tgt = TGT_ROMLOW; r.off = a - ROMLOW_BASE; hit = 1'b1;
                    end else if (hi_rom && !game && port_reg[1] && a >= BASIC_BASE
                                 && a <= BASIC_TOP) begin
                        r.tgt = TGT_ROMHIGH; r.off = a - BASIC_BASE; hit = 1'b1;
                    end
                end
            end
            if (!hit) begin
                if (basic_vis && a >= BASIC_BASE && a <= BASIC_TOP) begin
                    r.tgt = TGT_BASIC; r.off = a - BASIC_BASE;
                end else if (kern_vis && a >= KERNEL_BASE) begin
                    r.tgt = TGT_KERNEL; r.off = a - KERNEL_BASE;
                end else if (io_vis && in_io) begin
                    r = decode_io(a, 1'b0, r);
                end else if (chr_vis && in_io) begin
                    r.tgt = TGT_CHARROM; r.off = a - 16'hd000;
                end else if (a == PORT_ADDR) begin
                    r.tgt = TGT_PORT; r.off = '0; r.rd = port_reg;
                end
            end
        end
        return r;
    endfunction

    task automatic send_access(input logic wr, input logic [15:0] addr, input logic [7:0] wd,
                               input logic typed, input access_result_t want);
        access_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {wd, addr};
        s_tuser  <= wr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = decode_access(wr, addr, wd);
        expected_results.push_back(typed ? want : predicted);
        n_accesses++;
    endtask

    task automatic apb_transfer(input logic wr, input logic [PADDR_W-1:0] addr,
                                input logic [31:0] wd, output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wd;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
    endtask

    // Drain the pipeline, then write and read back all six bits
    task automatic program_config(input logic [5:0] cfg);
        logic [31:0] rd;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        foreach (CFG_REGS[i])
            apb_transfer(1'b1, {CFG_REGS[i], 2'b00}, {31'd0, cfg[CFG_REGS[i]]}, rd);
        foreach (CFG_REGS[i]) begin
            apb_transfer(1'b0, {CFG_REGS[i], 2'b00}, 32'd0, rd);
            if (rd != {31'd0, cfg[CFG_REGS[i]]})
                flag_error("config readback", rd, cfg[CFG_REGS[i]]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        cfg_now = cfg;
        n_configs++;
    endtask

    always @(posedge aclk) begin
        access_result_t want_res;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                flag_error("transfer with nothing expected", m_tdata, 0);
            end else begin
                want_res = expected_results.pop_front();
                if (m_tuser[3:0] != want_res.tgt)   flag_error("target", m_tuser[3:0], want_res.tgt);
                if (m_tdata[15:0] != want_res.off)  flag_error("offset", m_tdata[15:0], want_res.off);
                if (m_tdata[23:16] != want_res.rd)  flag_error("read_data", m_tdata[23:16], want_res.rd);
                if (m_tuser[4] != want_res.copy)    flag_error("ram_copy", m_tuser[4], want_res.copy);
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        logic [15:0] addr;
        logic [7:0]  wd;
        logic        wr;
        logic [5:0]  cfg;
        int          sel;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].cfg != cfg_now) program_config(DIR_ROWS[i].cfg);
            send_access(DIR_ROWS[i].wr, DIR_ROWS[i].addr, DIR_ROWS[i].wd,
                        DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            cfg = (p < 6) ? PHASE_CFG[p] : 6'($urandom);
            program_config(cfg);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            for (int n = 0; n < PHASE_LEN; n++) begin
                sel = $urandom_range(15);
                // weight toward the banked windows and the I/O page
                case (sel)
                    0, 1:        addr = PORT_ADDR;
                    2:           addr = 16'($urandom_range(16'h00ff));
                    3, 4:        addr = 16'($urandom_range(16'h9fff, 16'h8000));
                    5, 6:        addr = 16'($urandom_range(16'hbfff, 16'ha000));
                    7:           addr = 16'($urandom_range(16'hcfff, 16'hc000));
                    8, 9, 10, 11: addr = 16'($urandom_range(16'hdfff, 16'hd000));
                    12, 13:      addr = 16'($urandom_range(16'hffff, 16'he000));
                    default:     addr = 16'($urandom);
                endcase
                wr = ($urandom_range(1) == 1) ? ACC_WR : ACC_RD;
                wd = 8'($urandom);
                send_access(wr, addr, wd, 1'b0, NO_EXP);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("Checked %0d results from %0d accesses across %0d config settings",
                 n_results, n_accesses, n_configs);
        $display("with directed region and port cases plus weighted random traffic.");
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
